/* hdl/bpt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package bpt_pkg;

  // Request operation codes.
  localparam logic [2:0] OP_GET        = 3'd0;
  localparam logic [2:0] OP_GET_PIN    = 3'd1;
  localparam logic [2:0] OP_ANON       = 3'd2;
  localparam logic [2:0] OP_ANON_PIN   = 3'd3;
  localparam logic [2:0] OP_UNPIN      = 3'd4;
  localparam logic [2:0] OP_MARK_DIRTY = 3'd5;

  // Response status codes.
  localparam logic [2:0] ST_HIT     = 3'd0;
  localparam logic [2:0] ST_FILLED  = 3'd1;
  localparam logic [2:0] ST_EVICTED = 3'd2;
  localparam logic [2:0] ST_FAILED  = 3'd3;
  localparam logic [2:0] ST_SLOT_OP = 3'd4;

  localparam logic [6:0]  VICTIM_LIMIT     = 7'd100;
  localparam logic [6:0]  USES_MAX         = 7'd127;
  localparam logic [31:0] ANON_PAGE        = 32'hFFFF_FFFF;
  localparam logic [4:0]  POOL_PAGES_RESET = 5'd16;

  typedef struct packed {
    logic [2:0]  operation;
    logic [7:0]  table_id;
    logic [31:0] page_index;
    logic [3:0]  slot_sel;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  slot;
    logic        writeback_valid;
    logic [7:0]  wb_table_id;
    logic        wb_anonymous;
    logic [31:0] wb_page_index;
  } rsp_t;

  // One page table entry as held in the entry memory.
  typedef struct packed {
    logic [7:0]  table_id;
    logic [31:0] page_index;
    logic        anon;
    logic        pinned;
    logic        dirty;
    logic [6:0]  uses;
  } entry_t;

endpackage

`default_nettype wire

/* hdl/bpt_entry_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module bpt_entry_ram
  import bpt_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire entry_t        wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output entry_t             rd_data
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* hdl/bpt_seq.sv */
`timescale 1ns / 1ps
`default_nettype none

module bpt_seq
  import bpt_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire req_t                       in_data,
  input  wire logic [$clog2(SLOTS+1)-1:0] cap,
  input  wire logic                       out_free,
  output logic                            done,
  output rsp_t                            rsp
);

  localparam int IW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW   = $clog2(SLOTS + 1);
  localparam int CMPW = (CW > 5) ? CW : 5;

  typedef enum logic [2:0] {
    S_IDLE, S_SLOTOP, S_HSCAN, S_MISS, S_VSCAN, S_VEND, S_FINISH
  } state_t;

  state_t          state;
  req_t            req;
  logic [CW-1:0]   filled;
  logic [CW-1:0]   issue_cnt;
  logic            rd_vld;
  logic            rd_last;
  logic [IW-1:0]   rd_idx;
  logic [6:0]      best;
  logic [IW-1:0]   victim;
  logic            found;
  entry_t          vic_ent;

  logic            ram_we;
  logic [IW-1:0]   ram_waddr;
  entry_t          ram_wdata;
  logic            ram_re;
  logic [IW-1:0]   ram_raddr;
  entry_t          ram_rdata;

  logic            issue;
  logic            hit;
  logic            scan_end;
  logic            in_sel_ok;
  logic            req_anon;
  logic            req_pin;
  entry_t          upd;
  entry_t          new_ent;

  bpt_entry_ram #(
    .DEPTH (SLOTS),
    .AW    (IW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  always_comb begin
    req_anon  = req.operation[1];
    req_pin   = req.operation[0];
    issue     = (issue_cnt < filled);
    hit       = rd_vld && !ram_rdata.anon && (ram_rdata.table_id == req.table_id) &&
                (ram_rdata.page_index == req.page_index);
    scan_end  = (rd_vld && rd_last) || (filled == '0);
    in_sel_ok = (CMPW'(in_data.slot_sel) < CMPW'(filled));
    in_ready  = (state == S_IDLE);
    done      = (state == S_FINISH) && out_free;

    new_ent.table_id   = req_anon ? 8'd0 : req.table_id;
    new_ent.page_index = req_anon ? ANON_PAGE : req.page_index;
    new_ent.anon       = req_anon;
    new_ent.pinned     = req_pin;
    new_ent.dirty      = 1'b0;
    new_ent.uses       = 7'd1;

    upd = ram_rdata;

    ram_re    = 1'b0;
    ram_raddr = issue_cnt[IW-1:0];
    ram_we    = 1'b0;
    ram_waddr = rd_idx;
    ram_wdata = new_ent;

    unique case (state)
      S_IDLE: begin
        ram_raddr = IW'(in_data.slot_sel);
        ram_re    = in_valid && in_sel_ok &&
                    ((in_data.operation == OP_UNPIN) || (in_data.operation == OP_MARK_DIRTY));
      end
      S_SLOTOP: begin
        if (req.operation == OP_UNPIN) begin
          upd.pinned = 1'b0;
        end else begin
          upd.dirty = 1'b1;
        end
        ram_we    = 1'b1;
        ram_waddr = IW'(req.slot_sel);
        ram_wdata = upd;
      end
      S_HSCAN: begin
        ram_re = issue;
        if (ram_rdata.uses != USES_MAX) begin
          upd.uses = ram_rdata.uses + 7'd1;
        end
        upd.pinned = ram_rdata.pinned | req_pin;
        ram_we     = hit;
        ram_wdata  = upd;
      end
      S_MISS: begin
        ram_we    = (filled < cap);
        ram_waddr = filled[IW-1:0];
      end
      S_VSCAN: begin
        ram_re = issue;
      end
      S_VEND: begin
        ram_we    = found;
        ram_waddr = victim;
      end
      S_FINISH: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      filled <= '0;
      rd_vld <= 1'b0;
    end else begin
      // Read pipeline shared by both scans: one entry issued per cycle.
      if ((state == S_HSCAN) || (state == S_VSCAN)) begin
        if (issue) begin
          issue_cnt <= issue_cnt + CW'(1);
          rd_idx    <= issue_cnt[IW-1:0];
          rd_last   <= (CW'(issue_cnt + CW'(1)) == filled);
        end
        rd_vld <= issue;
      end else begin
        rd_vld    <= 1'b0;
        issue_cnt <= '0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            req                 <= in_data;
            rsp.writeback_valid <= 1'b0;
            rsp.wb_table_id     <= '0;
            rsp.wb_anonymous    <= 1'b0;
            rsp.wb_page_index   <= '0;
            priority if ((in_data.operation == OP_UNPIN) ||
                         (in_data.operation == OP_MARK_DIRTY)) begin
              rsp.status <= ST_SLOT_OP;
              rsp.slot   <= in_data.slot_sel;
              state      <= in_sel_ok ? S_SLOTOP : S_FINISH;
            end else if (in_data.operation[2]) begin
              rsp.status <= ST_SLOT_OP;
              rsp.slot   <= '0;
              state      <= S_FINISH;
            end else if (in_data.operation[1]) begin
              rsp.status <= ST_HIT;
              rsp.slot   <= '0;
              state      <= S_MISS;
            end else begin
              rsp.status <= ST_HIT;
              rsp.slot   <= '0;
              state      <= S_HSCAN;
            end
          end
        end
        S_SLOTOP: begin
          state <= S_FINISH;
        end
        S_HSCAN: begin
          if (hit) begin
            rsp.status <= ST_HIT;
            rsp.slot   <= 4'(rd_idx);
            state      <= S_FINISH;
          end else if (scan_end) begin
            state <= S_MISS;
          end
        end
        S_MISS: begin
          if (filled < cap) begin
            filled     <= filled + CW'(1);
            rsp.status <= ST_FILLED;
            rsp.slot   <= 4'(filled);
            state      <= S_FINISH;
          end else begin
            best   <= VICTIM_LIMIT;
            found  <= 1'b0;
            victim <= '0;
            state  <= S_VSCAN;
          end
        end
        S_VSCAN: begin
          if (rd_vld && !ram_rdata.pinned && (ram_rdata.uses <= best)) begin
            best    <= ram_rdata.uses;
            victim  <= rd_idx;
            found   <= 1'b1;
            vic_ent <= ram_rdata;
          end
          if (scan_end) begin
            state <= S_VEND;
          end
        end
        S_VEND: begin
          if (found) begin
            rsp.status <= ST_EVICTED;
            rsp.slot   <= 4'(victim);
            if (vic_ent.dirty) begin
              rsp.writeback_valid <= 1'b1;
              rsp.wb_table_id     <= vic_ent.table_id;
              rsp.wb_anonymous    <= vic_ent.anon;
              rsp.wb_page_index   <= vic_ent.page_index;
            end
          end else begin
            rsp.status <= ST_FAILED;
          end
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state != S_IDLE))
    else $error("request accepted but sequencer stayed idle");

  a_fill_only_on_miss: assert property (@(posedge clk) disable iff (rst)
    (filled != $past(filled)) |-> ($past(state) == S_MISS))
    else $error("fill count changed outside miss handling");

  a_no_write_when_idle: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state != S_IDLE) && (state != S_FINISH))
    else $error("entry memory written while no request in progress");

  a_done_needs_room: assert property (@(posedge clk) disable iff (rst)
    done |=> (state == S_IDLE))
    else $error("response issued without returning to idle");
`endif

endmodule

`default_nettype wire

/* hdl/buffer_pool_page_table_unit.sv */
// A slot operation acts only on the slot it names; a named request scans the filled slots
// in order and stops at a hit; a miss with free room fills the next free slot.
// A named miss on a full pool runs two read passes through the single read port of the
// entry memory, the hit scan and then the victim scan; an anonymous one runs the second only.
// Throughput: one request at a time; the next is taken once the response is registered.
// Reset: synchronous; empties the pool and sets pool_pages to 16. Entries are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module buffer_pool_page_table_unit
  import bpt_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire req_t       in_data,
  output logic            out_valid,
  input  wire logic       out_ready,
  output rsp_t            out_data,
  input  wire logic       cfg_we,
  input  wire logic [4:0] cfg_wdata
);

  localparam int CW   = $clog2(SLOTS + 1);
  localparam int CMPW = (CW > 5) ? CW : 5;

  // Number of pool slots that may be used, as written through the configuration port.
  logic [4:0]    pool_pages;
  // Effective capacity: the smaller of the register and the physical slot count.
  logic [CW-1:0] cap;
  logic          out_free;
  logic          seq_done;
  rsp_t          seq_rsp;

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_pages <= POOL_PAGES_RESET;
    end else if (cfg_we) begin
      pool_pages <= cfg_wdata;
    end
  end

  always_comb begin
    if (CMPW'(pool_pages) < CMPW'(SLOTS)) begin
      cap = CW'(pool_pages);
    end else begin
      cap = CW'(SLOTS);
    end
  end

  // The output register is free when empty or when its response leaves this cycle, so the
  // sequencer can hand over a new response while the previous one is being taken.
  assign out_free = !out_valid || out_ready;

  // The sequencer owns the entry memory and walks each request through its scans.
  bpt_seq #(
    .SLOTS (SLOTS)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .cap      (cap),
    .out_free (out_free),
    .done     (seq_done),
    .rsp      (seq_rsp)
  );

  // Response register between the sequencer and the output channel.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (seq_done) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (seq_done) begin
      out_data <= seq_rsp;
    end
  end

`ifndef SYNTH
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !seq_done)
    else $error("pending response overwritten");

  a_accept_empties_pipe: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second request taken while one is in progress");

  a_resp_status_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.status == ST_HIT) || (out_data.status == ST_FILLED) ||
                  (out_data.status == ST_EVICTED) || (out_data.status == ST_FAILED) ||
                  (out_data.status == ST_SLOT_OP))
    else $error("response carries an undefined status");
`endif

endmodule

`default_nettype wire

/* dv/bpt_response_check.sv */
`timescale 1ns / 1ps

// Watches the request, configuration and response channels of the page table, keeps its own copy of the
// pool and predicts every response in order of acceptance.
module bpt_response_check
  import bpt_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic in_ready,
  input  req_t in_data,
  input  logic out_valid,
  input  logic out_ready,
  input  rsp_t out_data,
  input  logic cfg_we,
  input  logic [4:0] cfg_wdata,
  output int   mismatches,
  output int   outstanding
);

  entry_t     page_table [SLOTS];
  int         filled;
  logic [4:0] pool_pages;
  rsp_t       awaited_responses [$];
  int         reported;

  function automatic entry_t fresh_entry(input req_t r, input bit anon, input bit pin);
    entry_t e;
    e.table_id   = anon ? 8'd0 : r.table_id;
    e.page_index = anon ? ANON_PAGE : r.page_index;
    e.anon       = anon;
    e.pinned     = pin;
    e.dirty      = 1'b0;
    e.uses       = 7'd1;
    return e;
  endfunction

  // Applies one request to the local pool and returns the response it must give.
  function automatic rsp_t resolve_request(input req_t r);
    rsp_t rsp;
    int   cap;
    int   victim;
    int   best;
    bit   anon;
    bit   pin;
    rsp = '0;
    cap = (int'(pool_pages) > SLOTS) ? SLOTS : int'(pool_pages);
    case (r.operation)
      OP_UNPIN, OP_MARK_DIRTY: begin
        // Slot operations on a slot that was never filled change nothing.
        if (int'(r.slot_sel) < filled) begin
          if (r.operation == OP_UNPIN) page_table[r.slot_sel].pinned = 1'b0;
          else page_table[r.slot_sel].dirty = 1'b1;
        end
        rsp.status = ST_SLOT_OP;
        rsp.slot   = r.slot_sel;
        return rsp;
      end
      OP_GET, OP_GET_PIN, OP_ANON, OP_ANON_PIN: ;
      default: begin
        rsp.status = ST_SLOT_OP;
        return rsp;
      end
    endcase
    anon = (r.operation == OP_ANON) || (r.operation == OP_ANON_PIN);
    pin  = (r.operation == OP_GET_PIN) || (r.operation == OP_ANON_PIN);
    if (!anon) begin
      for (int i = 0; i < filled; i++) begin
        if (!page_table[i].anon && page_table[i].table_id == r.table_id &&
            page_table[i].page_index == r.page_index) begin
          if (page_table[i].uses != USES_MAX) page_table[i].uses++;
          if (pin) page_table[i].pinned = 1'b1;
          rsp.status = ST_HIT;
          rsp.slot   = 4'(i);
          return rsp;
        end
      end
    end
    if (filled < cap) begin
      page_table[filled] = fresh_entry(r, anon, pin);
      rsp.status = ST_FILLED;
      rsp.slot   = 4'(filled);
      filled++;
      return rsp;
    end
    // Full pool: lowest count at or below the limit among unpinned slots, the later slot on a tie.
    victim = -1;
    best   = int'(VICTIM_LIMIT);
    for (int i = 0; i < filled; i++) begin
      if (!page_table[i].pinned && int'(page_table[i].uses) <= best) begin
        best   = int'(page_table[i].uses);
        victim = i;
      end
    end
    if (victim < 0) begin
      rsp.status = ST_FAILED;
      return rsp;
    end
    rsp.status = ST_EVICTED;
    rsp.slot   = 4'(victim);
    if (page_table[victim].dirty) begin
      rsp.writeback_valid = 1'b1;
      rsp.wb_table_id     = page_table[victim].table_id;
      rsp.wb_anonymous    = page_table[victim].anon;
      rsp.wb_page_index   = page_table[victim].page_index;
    end
    page_table[victim] = fresh_entry(r, anon, pin);
    return rsp;
  endfunction

  initial begin
    mismatches = 0;
    reported   = 0;
  end

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      filled     = 0;
      pool_pages = POOL_PAGES_RESET;
      awaited_responses.delete();
    end else begin
      if (cfg_we) pool_pages = cfg_wdata;
      if (in_valid && in_ready) awaited_responses.push_back(resolve_request(in_data));
      if (out_valid && out_ready) begin
        if (awaited_responses.size() == 0) begin
          mismatches++;
          if (reported < 10) begin
            reported++;
            $display("%0t: response with no request outstanding: status %0d slot %0d",
                     $realtime, out_data.status, out_data.slot);
          end
        end else begin
          want = awaited_responses.pop_front();
          if (out_data.status !== want.status || out_data.slot !== want.slot ||
              out_data.writeback_valid !== want.writeback_valid ||
              out_data.wb_table_id !== want.wb_table_id ||
              out_data.wb_anonymous !== want.wb_anonymous ||
              out_data.wb_page_index !== want.wb_page_index) begin
            mismatches++;
            if (reported < 10) begin
              reported++;
              $display("%0t: response mismatch, expected status %0d slot %0d wb %0b %0d/%0b/%h",
                       $realtime, want.status, want.slot, want.writeback_valid,
                       want.wb_table_id, want.wb_anonymous, want.wb_page_index);
              $display("%0t:                     actual status %0d slot %0d wb %0b %0d/%0b/%h",
                       $realtime, out_data.status, out_data.slot, out_data.writeback_valid,
                       out_data.wb_table_id, out_data.wb_anonymous, out_data.wb_page_index);
            end
          end
        end
      end
    end
    outstanding <= awaited_responses.size();
  end

endmodule

/* dv/buffer_pool_page_table_unit_test.sv */
`timescale 1ns / 1ps

// Stimulus and verdict for the buffer pool page table. The response check sits
// beside the block, predicts every response and counts the mismatches; this
// module only drives requests, configuration and back-pressure.
module buffer_pool_page_table_unit_test;
  import bpt_pkg::*;

  // Operation codes the block does not define; they must answer as a slot
  // operation on slot 0 and leave the pool alone.
  localparam logic [2:0] OP_SPARE_A = 3'd6;
  localparam logic [2:0] OP_SPARE_B = 3'd7;

  // This pause outlasts the slowest request, a miss on a full pool of sixteen
  // slots, so it covers any request still in flight.
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASES        = 9;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  req_t       in_data   = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  rsp_t       out_data;
  logic       cfg_we    = 1'b0;
  logic [4:0] cfg_wdata = '0;

  int mismatches;
  int outstanding;

  // When set, neither side inserts gaps, so requests arrive back to back.
  bit steady = 1'b0;

  // Random phases: pool size, size of the working set of pages, number of
  // requests, and whether the run is free of idling. A working set of one
  // page drives a single slot's use count past the eviction limit and into
  // saturation. The last pool size is drawn at random before the loop.
  int plan_pages  [PHASES] = '{16, 2, 1, 31, 4, 0, 8, 3, 16};
  int plan_spread [PHASES] = '{24, 3, 2, 1, 6, 4, 12, 5, 8};
  int plan_count  [PHASES] = '{150, 150, 100, 250, 150, 60, 150, 150, 200};
  bit plan_steady [PHASES] = '{0, 0, 1, 0, 0, 0, 1, 0, 0};

  buffer_pool_page_table_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  bpt_response_check u_check (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Presents one request after a random gap and returns at the edge where it
  // is taken. Valid is only lowered when a gap follows, so back-to-back
  // requests keep it high without a glitch.
  task automatic send_request(input req_t r);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic issue(input logic [2:0] op, input logic [7:0] tab,
                       input logic [31:0] page, input logic [3:0] sel);
    req_t r;
    r.operation  = op;
    r.table_id   = tab;
    r.page_index = page;
    r.slot_sel   = sel;
    send_request(r);
  endtask

  // Called at the edge where the last request of a stretch was taken: drops
  // valid, waits for every response and lets the block fall idle.
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    wait (outstanding == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_pool_pages(input logic [4:0] pages);
    cfg_we    <= 1'b1;
    cfg_wdata <= pages;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Random request. Most named requests come from a small working set so that
  // hits, pins and evictions of known pages are frequent; the rest use fully
  // random identities, and a few look like an anonymous entry.
  function automatic req_t random_request(input int spread, input int cap);
    req_t r;
    int   pick;
    int   idx;
    int   stray;
    pick = $urandom_range(0, 99);
    if (pick < 40)      r.operation = OP_GET;
    else if (pick < 55) r.operation = OP_GET_PIN;
    else if (pick < 63) r.operation = OP_ANON;
    else if (pick < 68) r.operation = OP_ANON_PIN;
    else if (pick < 81) r.operation = OP_UNPIN;
    else if (pick < 96) r.operation = OP_MARK_DIRTY;
    else if (pick < 98) r.operation = OP_SPARE_A;
    else                r.operation = OP_SPARE_B;
    stray = (spread == 1) ? 5 : 25;
    pick  = $urandom_range(0, 99);
    idx   = $urandom_range(0, spread - 1);
    if (pick < stray) begin
      r.table_id   = 8'($urandom);
      r.page_index = $urandom;
    end else if (pick < stray + 4) begin
      r.table_id   = 8'd0;
      r.page_index = ANON_PAGE;
    end else begin
      r.table_id   = 8'((idx % 3) * 127);
      r.page_index = idx[0] ? ~32'(idx) : 32'(idx);
    end
    // Slot operations mostly aim at slots the pool can hold.
    if (cap > 0 && $urandom_range(0, 99) < 80) r.slot_sel = 4'($urandom_range(0, cap - 1));
    else r.slot_sel = 4'($urandom_range(0, 15));
    return r;
  endfunction

  // Back-pressure on the response side: a fresh stall before each response.
  initial begin
    int stall;
    wait (rst == 1'b0);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  initial begin
    int cap;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // With no capacity at all an empty pool already counts as full, so the
    // very first request fails.
    write_pool_pages(5'd0);
    issue(OP_GET, 8'd0, 32'd0, 4'd0);
    drain();
    write_pool_pages(5'd16);

    // Fill a few slots. The named request for table 0, page all ones must not
    // match the anonymous entry, which is stored with exactly that identity.
    issue(OP_ANON, 8'hA5, 32'h1234_5678, 4'd9);
    issue(OP_GET, 8'd0, ANON_PAGE, 4'd0);
    issue(OP_GET, 8'd255, 32'd0, 4'd0);
    issue(OP_GET_PIN, 8'd255, 32'd0, 4'd0);
    issue(OP_GET, 8'd0, ANON_PAGE, 4'd0);
    issue(OP_MARK_DIRTY, 8'd0, 32'd0, 4'd1);
    issue(OP_MARK_DIRTY, 8'd0, 32'd0, 4'd0);
    // Slot operations on an unfilled slot, and both undefined operations.
    issue(OP_UNPIN, 8'd0, 32'd0, 4'd15);
    issue(OP_MARK_DIRTY, 8'd0, 32'd0, 4'd15);
    issue(OP_SPARE_A, 8'd255, ANON_PAGE, 4'd15);
    issue(OP_SPARE_B, 8'd255, ANON_PAGE, 4'd15);
    issue(OP_ANON_PIN, 8'd0, 32'd0, 4'd0);
    drain();

    // Shrink the pool below its fill level: every miss now needs a victim. The
    // dirty anonymous slot goes first, then a tie on the use count picks the
    // later slot, then with all slots pinned a request fails until an unpin.
    write_pool_pages(5'd2);
    issue(OP_GET, 8'd1, 32'd1, 4'd0);
    issue(OP_GET, 8'd1, 32'd1, 4'd0);
    issue(OP_ANON_PIN, 8'd0, 32'd0, 4'd0);
    issue(OP_GET_PIN, 8'd1, 32'd1, 4'd0);
    issue(OP_GET, 8'd2, 32'd2, 4'd0);
    issue(OP_UNPIN, 8'd0, 32'd0, 4'd2);
    issue(OP_GET, 8'd2, 32'd2, 4'd0);
    drain();

    plan_pages[PHASES - 1] = $urandom_range(0, 31);
    for (int p = 0; p < PHASES; p++) begin
      write_pool_pages(5'(plan_pages[p]));
      steady = plan_steady[p];
      cap = (plan_pages[p] > 16) ? 16 : plan_pages[p];
      repeat (plan_count[p]) send_request(random_request(plan_spread[p], cap));
      drain();
      steady = 1'b0;
    end

    if (mismatches == 0 && outstanding == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Hard stop, several times the slowest correct run.
  initial begin
    #8000000;
    $display("Some tests failed");
    $finish;
  end

endmodule

/* sim.f */
hdl/bpt_pkg.sv
hdl/bpt_entry_ram.sv
hdl/bpt_seq.sv
hdl/buffer_pool_page_table_unit.sv
dv/bpt_response_check.sv
dv/buffer_pool_page_table_unit_test.sv
